[rtl/smx_pkg.sv]
package smx_pkg;

	localparam int unsigned DATA_W = 32;

	// opcodes
	localparam logic [3:0] OP_PUSH = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_MUL  = 4'd3;
	localparam logic [3:0] OP_DIV  = 4'd4;
	localparam logic [3:0] OP_DUP  = 4'd5;
	localparam logic [3:0] OP_SWAP = 4'd6;
	localparam logic [3:0] OP_MOD  = 4'd7;
	localparam logic [3:0] OP_NEG  = 4'd8;
	localparam logic [3:0] OP_ABS  = 4'd9;
	localparam logic [3:0] OP_POP  = 4'd10;
	localparam logic [3:0] OP_HALT = 4'd11;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_UNDER = 3'd3;
	localparam logic [2:0] ST_DIVZ  = 3'd4;
	localparam logic [2:0] ST_BADOP = 3'd5;
	localparam logic [2:0] ST_IDLE  = 3'd6;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [1:0] need_ops(input logic [3:0] op);
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_MOD: need_ops = 2'd2;
			OP_DUP, OP_NEG, OP_ABS, OP_POP:                  need_ops = 2'd1;
			default:                                         need_ops = 2'd0;
		endcase
	endfunction

endpackage

[rtl/smx_ram.sv]
module smx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/smx_div.sv]
module smx_div (
	input  logic              clk,
	input  logic              arst_n,
	input  smx_pkg::div_req_t req,
	output smx_pkg::div_rsp_t rsp
);
	import smx_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [4:0]          step_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W-1:0]   dvs_q;
	logic                negq_q;
	logic                negr_q;
	logic [DATA_W:0]     shifted;
	logic [DATA_W:0]     diff;
	logic [DATA_W-1:0]   a_mag;
	logic [DATA_W-1:0]   b_mag;

	assign a_mag   = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign b_mag   = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, unsigned magnitudes
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= a_mag;
			dvs_q  <= b_mag;
			negq_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
			negr_q <= req.dividend[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = negq_q ? (~quo_q + 1'b1) : quo_q;
	assign rsp.rem  = negr_q ? (~rem_q + 1'b1) : rem_q;

endmodule

[rtl/stack_machine_executor.sv]
// channel | signals                              | direction
// in      | in_valid, in_stall, kind, immediate  | instructions in
// out     | out_valid, out_stall, status,        | one result per item
//         | top_value, top_valid, depth          |
//
// Most items pass through S_IDLE, where the entry below the cached top is read from
// the stack RAM, and S_EXEC, which executes and writes back. div and mod with a
// nonzero divisor then wait in S_DIV for the radix-2 divider (one quotient bit per cycle).
// Reset clears the count and restarts the machine; no RAM clearing pass.
// A new item is taken in S_IDLE unless out_stall still holds the previous result.
module stack_machine_executor #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [31:0] immediate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] top_value,
	output logic        top_valid,
	output logic [7:0]  depth
);
	import smx_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0]        state_q;
	logic [3:0]        op_q;
	logic [31:0]       imm_q;
	logic [31:0]       top_q;
	logic [CW-1:0]     cnt_q;
	logic              running_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [31:0]       top_value_q;
	logic              top_valid_q;
	logic [7:0]        depth_q;

	logic              in_acc;
	logic [31:0]       rd_data;
	logic [AW-1:0]     addr_m1;
	logic [AW-1:0]     addr_m2;
	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic [31:0]       prod_lo;

	logic              ex_done;
	logic [2:0]        nxt_status;
	logic [31:0]       nxt_top;
	logic [CW-1:0]     nxt_cnt;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CW+7:0]     cnt_ext;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign cnt_m1  = cnt_q - CW'(1);
	assign cnt_m2  = cnt_q - CW'(2);
	assign addr_m1 = cnt_m1[AW-1:0];
	assign addr_m2 = cnt_m2[AW-1:0];
	assign prod_lo = rd_data * top_q;

	// RAM holds entries below the top; the top lives in top_q
	smx_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(top_q),
		.raddr(addr_m2),
		.rdata(rd_data)
	);

	smx_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		ex_done        = 1'b0;
		nxt_status     = ST_OK;
		nxt_top        = top_q;
		nxt_cnt        = cnt_q;
		ram_we         = 1'b0;
		ram_waddr      = addr_m1;
		div_req.start    = 1'b0;
		div_req.dividend = rd_data;
		div_req.divisor  = top_q;
		if (state_q == S_EXEC) begin
			ex_done = 1'b1;
			if (!running_q) begin
				nxt_status = ST_IDLE;
			end else if (op_q > OP_HALT) begin
				nxt_status = ST_BADOP;
			end else if (op_q == OP_HALT) begin
				nxt_status = ST_HALT;
			end else if (cnt_q < CW'(need_ops(op_q))) begin
				nxt_status = ST_UNDER;
			end else if ((op_q == OP_PUSH || op_q == OP_DUP) &&
			             cnt_q == CW'(STACK_DEPTH)) begin
				nxt_status = ST_OVER;
			end else begin
				case (op_q)
					OP_PUSH: begin
						ram_we  = (cnt_q != '0);
						nxt_top = imm_q;
						nxt_cnt = cnt_q + CW'(1);
					end
					OP_DUP: begin
						ram_we  = 1'b1;
						nxt_cnt = cnt_q + CW'(1);
					end
					OP_POP: begin
						nxt_top = rd_data;
						nxt_cnt = cnt_m1;
					end
					OP_NEG: begin
						if (!top_q[31] && top_q != '0) begin
							nxt_top = ~top_q + 1'b1;
						end
					end
					OP_ABS: begin
						if (top_q[31]) begin
							nxt_top = ~top_q + 1'b1;
						end
					end
					OP_SWAP: begin
						ram_we    = 1'b1;
						ram_waddr = addr_m2;
						nxt_top   = rd_data;
					end
					OP_ADD: begin
						nxt_top = rd_data + top_q;
						nxt_cnt = cnt_m1;
					end
					OP_SUB: begin
						nxt_top = rd_data - top_q;
						nxt_cnt = cnt_m1;
					end
					OP_MUL: begin
						nxt_top = prod_lo;
						nxt_cnt = cnt_m1;
					end
					OP_DIV, OP_MOD: begin
						if (top_q == '0) begin
							nxt_status = ST_DIVZ;
						end else begin
							ex_done       = 1'b0;
							div_req.start = 1'b1;
						end
					end
					default: begin
						nxt_status = ST_BADOP;
					end
				endcase
			end
		end else if (state_q == S_DIV && div_rsp.done) begin
			ex_done = 1'b1;
			nxt_top = (op_q == OP_DIV) ? div_rsp.quot : div_rsp.rem;
			nxt_cnt = cnt_m1;
		end
	end

	assign cnt_ext = {8'd0, nxt_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			running_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= div_req.start ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ex_done) begin
				out_valid_q <= 1'b1;
				cnt_q       <= nxt_cnt;
				if (nxt_status != ST_OK) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= kind;
			imm_q <= immediate;
		end
		if (ex_done) begin
			top_q       <= nxt_top;
			status_q    <= nxt_status;
			top_value_q <= (nxt_cnt != '0) ? nxt_top : '0;
			top_valid_q <= (nxt_cnt != '0);
			depth_q     <= cnt_ext[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_value_q;
	assign top_valid = top_valid_q;
	assign depth     = depth_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |=> !running_q)
		else $error("machine restarted without reset");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ex_done |-> !out_valid_q)
		else $error("result overwrites a pending item");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");
`endif

endmodule

[bench/tb_stack_machine_executor.sv]
`timescale 1ns / 1ps

module tb_stack_machine_executor;
	import smx_pkg::*;

	localparam int unsigned STACK_DEPTH = 128;
	// opcodes the machine does not decode
	localparam logic [3:0] OP_BAD_LO = 4'd12;
	localparam logic [3:0] OP_BAD_HI = 4'd15;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] top_value;
		logic        top_valid;
		logic [7:0]  depth;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  kind = '0;
	logic [31:0] immediate = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] top_value;
	logic        top_valid;
	logic [7:0]  depth;

	// mirror of the machine state
	logic [31:0] stk_mem [STACK_DEPTH];
	int          stk_cnt = 0;
	bit          running = 1'b1;
	int          deepest = 0;

	result_t     pending_results[$];
	int          err_cnt = 0;
	int          sent_cnt = 0;
	int          ignored_cnt = 0;
	int          checked_cnt = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          stall_left = 0;
	string       stop_cause = "nothing";

	stack_machine_executor #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.immediate(immediate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.top_value(top_value),
		.top_valid(top_valid),
		.depth    (depth)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Timeout waiting for results");
		$display("Mismatches found");
		$finish;
	end

	function automatic int arg_count(input logic [3:0] op);
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_MOD: return 2;
			OP_DUP, OP_NEG, OP_ABS, OP_POP: return 1;
			default: return 0;
		endcase
	endfunction

	// executes one instruction on the mirror and returns the result it reports
	function automatic result_t exec_instr(input logic [3:0] op, input logic [31:0] imm);
		result_t     r;
		logic [2:0]  st;
		logic [31:0] lhs, rhs, res;
		longint      a, b;

		st = ST_OK;
		if (!running) begin
			st = ST_IDLE;
		end else if (op > OP_HALT) begin
			st = ST_BADOP;
		end else if (op == OP_HALT) begin
			st = ST_HALT;
		end else if (stk_cnt < arg_count(op)) begin
			st = ST_UNDER;
		end else if ((op == OP_PUSH || op == OP_DUP) && stk_cnt >= STACK_DEPTH) begin
			st = ST_OVER;
		end else begin
			case (op)
				OP_PUSH: begin
					stk_mem[stk_cnt] = imm;
					stk_cnt++;
				end
				OP_DUP: begin
					stk_mem[stk_cnt] = stk_mem[stk_cnt-1];
					stk_cnt++;
				end
				OP_POP: stk_cnt--;
				OP_NEG: begin
					if ($signed(stk_mem[stk_cnt-1]) > 0)
						stk_mem[stk_cnt-1] = -stk_mem[stk_cnt-1];
				end
				OP_ABS: begin
					if ($signed(stk_mem[stk_cnt-1]) < 0)
						stk_mem[stk_cnt-1] = -stk_mem[stk_cnt-1];
				end
				OP_SWAP: begin
					rhs = stk_mem[stk_cnt-1];
					stk_mem[stk_cnt-1] = stk_mem[stk_cnt-2];
					stk_mem[stk_cnt-2] = rhs;
				end
				default: begin
					rhs = stk_mem[stk_cnt-1];
					lhs = stk_mem[stk_cnt-2];
					a = $signed(lhs);
					b = $signed(rhs);
					if ((op == OP_DIV || op == OP_MOD) && b == 0) begin
						st = ST_DIVZ;
					end else begin
						// 64-bit math keeps most-negative / -1 well defined
						case (op)
							OP_ADD:  res = lhs + rhs;
							OP_SUB:  res = lhs - rhs;
							OP_MUL:  res = lhs * rhs;
							OP_DIV:  res = 32'(a / b);
							default: res = 32'(a % b);
						endcase
						stk_mem[stk_cnt-2] = res;
						stk_cnt--;
					end
				end
			endcase
		end
		if (st != ST_OK && st != ST_IDLE)
			running = 1'b0;
		if (stk_cnt > deepest)
			deepest = stk_cnt;
		r.status    = st;
		r.top_valid = (stk_cnt > 0);
		r.top_value = (stk_cnt > 0) ? stk_mem[stk_cnt-1] : '0;
		r.depth     = 8'(stk_cnt);
		return r;
	endfunction

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0000;
					default: return 32'h0000_0001;
				endcase
			end
			1, 2, 3: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	// random op that keeps the machine running
	function automatic logic [3:0] legal_op();
		logic [3:0] op;
		int         push_pct;

		push_pct = (stk_cnt < 4) ? 50 : ((stk_cnt > 16) ? 10 : 30);
		if ($urandom_range(0, 99) < push_pct)
			op = OP_PUSH;
		else
			op = 4'($urandom_range(OP_PUSH, OP_POP));
		if (stk_cnt < arg_count(op))
			op = OP_PUSH;
		if ((op == OP_PUSH || op == OP_DUP) && stk_cnt >= STACK_DEPTH)
			op = OP_POP;
		if ((op == OP_DIV || op == OP_MOD) && stk_mem[stk_cnt-1] == 0)
			op = OP_SUB;
		return op;
	endfunction

	// call right after a rising edge; returns at the edge that takes the item
	task automatic send_instr(input logic [3:0] op, input logic [31:0] imm);
		int gap;

		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= op;
		immediate <= imm;
		do @(posedge clk); while (in_stall);
		if (!running)
			ignored_cnt++;
		pending_results.push_back(exec_instr(op, imm));
		sent_cnt++;
	endtask

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		err_cnt++;
		if (err_cnt <= 100)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		result_t want;

		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result, status", '0, 32'(status));
			end else begin
				want = pending_results.pop_front();
				checked_cnt++;
				if (status !== want.status)
					report("status", 32'(want.status), 32'(status));
				if (top_value !== want.top_value)
					report("top_value", want.top_value, top_value);
				if (top_valid !== want.top_valid)
					report("top_valid", 32'(want.top_valid), 32'(top_valid));
				if (depth !== want.depth)
					report("depth", 32'(want.depth), 32'(depth));
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// wraparound, truncation and sign corner cases on every op but halt
	task automatic test_directed();
		idle_pct  = 20;
		stall_pct = 20;
		send_instr(OP_PUSH, 32'h7fff_ffff);
		send_instr(OP_PUSH, 32'h0000_0001);
		send_instr(OP_ADD,  '0);
		send_instr(OP_PUSH, 32'h0000_0001);
		send_instr(OP_SUB,  32'hffff_ffff);
		send_instr(OP_PUSH, 32'h8000_0000);
		send_instr(OP_PUSH, 32'hffff_ffff);
		send_instr(OP_DIV,  '0);
		send_instr(OP_PUSH, 32'hffff_ffff);
		send_instr(OP_MOD,  '0);
		send_instr(OP_POP,  '0);
		send_instr(OP_PUSH, 32'h8000_0000);
		send_instr(OP_ABS,  '0);
		send_instr(OP_NEG,  '0);
		send_instr(OP_SWAP, '0);
		send_instr(OP_NEG,  '0);
		send_instr(OP_ABS,  '0);
		send_instr(OP_MUL,  '0);
		send_instr(OP_DUP,  '0);
		send_instr(OP_PUSH, 32'hffff_fff9);
		send_instr(OP_MOD,  '0);
		send_instr(OP_PUSH, 32'h0000_0002);
		send_instr(OP_DIV,  '0);
		send_instr(OP_PUSH, 32'h0000_0000);
		send_instr(OP_NEG,  '0);
	endtask

	// fill to full depth back to back, then work it down under backpressure
	task automatic test_fill_drain();
		idle_pct  = 0;
		stall_pct = 0;
		while (stk_cnt < STACK_DEPTH)
			send_instr(OP_PUSH, rand_imm());
		send_instr(OP_POP, rand_imm());
		send_instr(OP_DUP, rand_imm());
		idle_pct  = 30;
		stall_pct = 30;
		while (stk_cnt > 8)
			send_instr(legal_op(), rand_imm());
	endtask

	task automatic test_random();
		int pcts[4] = '{0, 10, 30, 60};

		for (int chunk = 0; chunk < 4; chunk++) begin
			idle_pct  = pcts[$urandom_range(0, 3)];
			stall_pct = pcts[$urandom_range(0, 3)];
			repeat (100) send_instr(legal_op(), rand_imm());
		end
	endtask

	// only one fault per run is possible; the seed picks which
	task automatic test_stop();
		logic [3:0] op;

		idle_pct  = 20;
		stall_pct = 20;
		case ($urandom_range(0, 4))
			0: begin
				stop_cause = "halt";
				send_instr(OP_HALT, rand_imm());
			end
			1: begin
				stop_cause = "underflow";
				while (stk_cnt > 1 || (stk_cnt == 1 && $urandom_range(0, 1) == 0))
					send_instr(OP_POP, rand_imm());
				if (stk_cnt == 0) begin
					op = 4'($urandom_range(OP_ADD, OP_POP));
				end else begin
					op = 4'($urandom_range(OP_ADD, OP_MOD));
					if (op == OP_DUP)
						op = OP_SWAP;
				end
				send_instr(op, rand_imm());
			end
			2: begin
				stop_cause = "overflow";
				while (stk_cnt < STACK_DEPTH)
					send_instr(OP_PUSH, rand_imm());
				send_instr($urandom_range(0, 1) ? OP_PUSH : OP_DUP, rand_imm());
			end
			3: begin
				stop_cause = "zero divisor";
				if (stk_cnt == 0)
					send_instr(OP_PUSH, rand_imm());
				send_instr(OP_PUSH, '0);
				send_instr($urandom_range(0, 1) ? OP_DIV : OP_MOD, rand_imm());
			end
			default: begin
				stop_cause = "unknown opcode";
				send_instr(4'($urandom_range(OP_BAD_LO, OP_BAD_HI)), rand_imm());
			end
		endcase
		repeat (20) send_instr(4'($urandom_range(OP_PUSH, OP_BAD_HI)), rand_imm());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain();
		test_random();
		test_stop();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Ran %0d instructions, %0d results checked, deepest stack %0d",
			sent_cnt, checked_cnt, deepest);
		$display("Machine stopped by %s, %0d later instructions ignored", stop_cause, ignored_cnt);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_div.sv
rtl/stack_machine_executor.sv
bench/tb_stack_machine_executor.sv
